### rtl/ccl_pkg.sv
// Console command line parser package: character codes, command codes and
// the letter-pair decode functions. No dependencies.

package ccl_pkg;

	localparam int CodeW = 5;
	localparam int MagW  = 31;
	localparam int ValW  = 32;

	localparam logic [MagW-1:0] MAG_MAX = {MagW{1'b1}};

	// Characters of interest
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_EQUAL = 8'h3D;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_1     = 8'h31;
	localparam logic [7:0] CH_2     = 8'h32;
	localparam logic [7:0] CH_9     = 8'h39;

	// Command codes
	localparam logic [CodeW-1:0] CMD_NONE = 5'd0;
	localparam logic [CodeW-1:0] CMD_ST   = 5'd1;
	localparam logic [CodeW-1:0] CMD_RT   = 5'd2;
	localparam logic [CodeW-1:0] CMD_TT   = 5'd3;
	localparam logic [CodeW-1:0] CMD_AC   = 5'd4;
	localparam logic [CodeW-1:0] CMD_AR   = 5'd5;
	localparam logic [CodeW-1:0] CMD_SM   = 5'd6;
	localparam logic [CodeW-1:0] CMD_PO   = 5'd7;
	localparam logic [CodeW-1:0] CMD_FA   = 5'd8;
	localparam logic [CodeW-1:0] CMD_Z1   = 5'd9;
	localparam logic [CodeW-1:0] CMD_Z2   = 5'd10;
	localparam logic [CodeW-1:0] CMD_D1   = 5'd11;
	localparam logic [CodeW-1:0] CMD_D2   = 5'd12;
	localparam logic [CodeW-1:0] CMD_T1   = 5'd13;
	localparam logic [CodeW-1:0] CMD_T2   = 5'd14;
	localparam logic [CodeW-1:0] CMD_V1   = 5'd15;
	localparam logic [CodeW-1:0] CMD_V2   = 5'd16;

	function automatic logic is_blank(input logic [7:0] c);
		return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
	endfunction

	function automatic logic is_first(input logic [7:0] c);
		return (c == "s") || (c == "r") || (c == "a") || (c == "z") || (c == "d") ||
			(c == "t") || (c == "v") || (c == "f") || (c == "p");
	endfunction

	// Second letter decode: simple pairs first, then z/d/t/v with 1 or 2
	function automatic logic [CodeW-1:0] pair_code(input logic [7:0] a, input logic [7:0] b);
		logic two;
		two = (b == CH_2);
		if (a == "s" && b == "t") return CMD_ST;
		if (a == "r" && b == "t") return CMD_RT;
		if (a == "t" && b == "t") return CMD_TT;
		if (a == "a" && b == "c") return CMD_AC;
		if (a == "a" && b == "r") return CMD_AR;
		if (a == "s" && b == "m") return CMD_SM;
		if (a == "p" && b == "o") return CMD_PO;
		if (a == "f" && b == "a") return CMD_FA;
		if (b != CH_1 && b != CH_2) return CMD_NONE;
		if (a == "z") return two ? CMD_Z2 : CMD_Z1;
		if (a == "d") return two ? CMD_D2 : CMD_D1;
		if (a == "t") return two ? CMD_T2 : CMD_T1;
		if (a == "v") return two ? CMD_V2 : CMD_V1;
		return CMD_NONE;
	endfunction

endpackage

### rtl/console_command_line_parser.sv
// Console command line parser, top level.
// Depends on ccl_pkg for character codes, command codes and pair decode.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one transaction per character:
//   action = 0 with char_code holding the character, or action = 1 to mark
//   the end of the line. Output channel (out_valid/out_ready) carries one
//   transaction per end of line: command_code and the signed cmd_value.
//   A character transaction updates the line state in the cycle it is
//   accepted and produces nothing. An end-of-line transaction loads the
//   output register, so the result is visible in the cycle after acceptance,
//   and clears the line state at the same edge.
//   Throughput is one transaction per cycle, save the stall below; the
//   per-character update is a single compare tree plus the multiply-by-ten
//   accumulate of the value. When the receiver stalls, characters are still
//   taken; only an end-of-line transaction waits while the output register
//   holds an untaken result.
//   Reset (arst_n low) clears the line state and empties the output register.
//   With no '=' on the line the result is code 0 and value 0; the value
//   magnitude saturates at 2147483647.

module console_command_line_parser
	import ccl_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic                   action,
	input  logic [7:0]             char_code,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [CodeW-1:0]       command_code,
	output logic signed [ValW-1:0] cmd_value
);

	// Line state
	logic [7:0]       first_letter_q;
	logic [CodeW-1:0] found_code_q;
	logic             equals_seen_q;
	logic             minus_seen_q;
	logic [MagW-1:0]  magnitude_q;
	logic             token_started_q;
	logic             token_ended_q;

	// Output register
	logic             out_valid_q;
	logic [CodeW-1:0] code_q;
	logic [ValW-1:0]  value_q;

	logic in_fire, char_fire, eol_fire;

	// Next-state of the line for one character
	logic [7:0]       first_letter_d;
	logic [CodeW-1:0] found_code_d;
	logic             equals_seen_d;
	logic             minus_seen_d;
	logic [MagW-1:0]  magnitude_d;
	logic             token_started_d;
	logic             token_ended_d;

	logic [MagW+3:0]  mag_times10;
	logic [MagW+3:0]  mag_sum;
	logic             is_digit;

	assign in_ready  = !out_valid_q || out_ready || !action;
	assign in_fire   = in_valid && in_ready;
	assign char_fire = in_fire && !action;
	assign eol_fire  = in_fire && action;

	// Decimal accumulate: m*10 + digit, saturated
	assign is_digit    = (char_code >= CH_0) && (char_code <= CH_9);
	assign mag_times10 = ({4'b0, magnitude_q} << 3) + ({4'b0, magnitude_q} << 1);
	assign mag_sum     = mag_times10 + {(MagW+4-4)'(0), char_code[3:0]};

	// Character update
	always_comb begin
		first_letter_d  = first_letter_q;
		found_code_d    = found_code_q;
		equals_seen_d   = equals_seen_q;
		minus_seen_d    = minus_seen_q;
		magnitude_d     = magnitude_q;
		token_started_d = token_started_q;
		token_ended_d   = token_ended_q;
		if (!token_ended_q) begin
			if (char_code == CH_NUL) begin
				token_ended_d = 1'b1;
			end else if (is_blank(char_code)) begin
				if (token_started_q) token_ended_d = 1'b1;
			end else begin
				token_started_d = 1'b1;
				if (first_letter_q == CH_NUL) begin
					if (is_first(char_code)) first_letter_d = char_code;
				end else if (equals_seen_q) begin
					if (is_digit) begin
						magnitude_d = (mag_sum > {4'b0, MAG_MAX}) ? MAG_MAX : mag_sum[MagW-1:0];
					end else if (char_code == CH_MINUS) begin
						minus_seen_d = 1'b1;
					end
				end else if (found_code_q != CMD_NONE) begin
					if (char_code == CH_EQUAL) equals_seen_d = 1'b1;
				end else begin
					found_code_d = pair_code(first_letter_q, char_code);
				end
			end
		end
	end

	// Line state registers; end of line clears them
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_letter_q  <= CH_NUL;
			found_code_q    <= CMD_NONE;
			equals_seen_q   <= 1'b0;
			minus_seen_q    <= 1'b0;
			magnitude_q     <= '0;
			token_started_q <= 1'b0;
			token_ended_q   <= 1'b0;
		end else if (eol_fire) begin
			first_letter_q  <= CH_NUL;
			found_code_q    <= CMD_NONE;
			equals_seen_q   <= 1'b0;
			minus_seen_q    <= 1'b0;
			magnitude_q     <= '0;
			token_started_q <= 1'b0;
			token_ended_q   <= 1'b0;
		end else if (char_fire) begin
			first_letter_q  <= first_letter_d;
			found_code_q    <= found_code_d;
			equals_seen_q   <= equals_seen_d;
			minus_seen_q    <= minus_seen_d;
			magnitude_q     <= magnitude_d;
			token_started_q <= token_started_d;
			token_ended_q   <= token_ended_d;
		end
	end

	// Output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (eol_fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output payload: only a line with '=' reports its command
	always_ff @(posedge clk) begin
		if (eol_fire) begin
			if (equals_seen_q) begin
				code_q  <= found_code_q;
				value_q <= minus_seen_q ? (ValW'(0) - {1'b0, magnitude_q}) : {1'b0, magnitude_q};
			end else begin
				code_q  <= CMD_NONE;
				value_q <= '0;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign command_code = code_q;
	assign cmd_value    = value_q;

endmodule

### dv/tb_console_command_line_parser.sv
// Testbench for console_command_line_parser: directed and random console lines,
// a scoreboard class that predicts each end-of-line result, and random idling.
// Depends on ccl_pkg and the console_command_line_parser RTL.

module tb_console_command_line_parser;
	import ccl_pkg::*;

	localparam int LIMIT_CYCLES = 200000;
	localparam int RANDOM_ITEMS = 580;
	localparam int LONG_HOLD    = 300;

	// Line predictor and store of expected commands
	class command_scoreboard;
		typedef struct {
			logic [CodeW-1:0]       code;
			logic signed [ValW-1:0] value;
		} line_result_t;

		logic [7:0]       lead_char;
		logic [CodeW-1:0] cmd_found;
		logic [MagW-1:0]  mag;
		bit               eq_seen, neg_seen, in_token, token_done;
		line_result_t     expected_commands[$];
		int               errors, checked;

		function new();
			clear_line();
			errors  = 0;
			checked = 0;
		endfunction

		function void clear_line();
			lead_char  = CH_NUL;
			cmd_found  = CMD_NONE;
			mag        = '0;
			eq_seen    = 1'b0;
			neg_seen   = 1'b0;
			in_token   = 1'b0;
			token_done = 1'b0;
		endfunction

		function int pending();
			return expected_commands.size();
		endfunction

		// Update line state for one accepted input transaction
		function void note_input(bit eol, logic [7:0] ch);
			logic [63:0]  acc;
			line_result_t cmd;
			if (eol) begin
				cmd.code  = eq_seen ? cmd_found : CMD_NONE;
				cmd.value = '0;
				if (eq_seen)
					cmd.value = neg_seen ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
				expected_commands.push_back(cmd);
				clear_line();
				return;
			end
			if (token_done)
				return;
			// NUL ends the token even before it starts
			if (ch == CH_NUL) begin
				token_done = 1'b1;
				return;
			end
			if (ch inside {CH_SPACE, CH_TAB, CH_CR, CH_LF}) begin
				if (in_token)
					token_done = 1'b1;
				return;
			end
			in_token = 1'b1;
			if (lead_char == CH_NUL) begin
				if (ch inside {"s", "r", "a", "z", "d", "t", "v", "f", "p"})
					lead_char = ch;
			end else if (eq_seen) begin
				if (ch >= CH_0 && ch <= CH_9) begin
					acc = 64'(mag) * 64'd10 + 64'(ch - CH_0);
					mag = (acc > 64'(MAG_MAX)) ? MAG_MAX : acc[MagW-1:0];
				end else if (ch == CH_MINUS) begin
					neg_seen = 1'b1;
				end
			end else if (cmd_found != CMD_NONE) begin
				if (ch == CH_EQUAL)
					eq_seen = 1'b1;
			end else begin
				// every later character is tried as the second letter
				case ({lead_char, ch})
					"st": cmd_found = CMD_ST;
					"rt": cmd_found = CMD_RT;
					"tt": cmd_found = CMD_TT;
					"ac": cmd_found = CMD_AC;
					"ar": cmd_found = CMD_AR;
					"sm": cmd_found = CMD_SM;
					"po": cmd_found = CMD_PO;
					"fa": cmd_found = CMD_FA;
					"z1": cmd_found = CMD_Z1;
					"z2": cmd_found = CMD_Z2;
					"d1": cmd_found = CMD_D1;
					"d2": cmd_found = CMD_D2;
					"t1": cmd_found = CMD_T1;
					"t2": cmd_found = CMD_T2;
					"v1": cmd_found = CMD_V1;
					"v2": cmd_found = CMD_V2;
					default: cmd_found = CMD_NONE;
				endcase
			end
		endfunction

		// Compare one output transaction with the oldest expectation
		function void check_command(logic [CodeW-1:0] code, logic signed [ValW-1:0] value);
			line_result_t exp_cmd;
			if (expected_commands.size() == 0) begin
				$error("unexpected result: command_code %0d cmd_value %0d", code, value);
				errors++;
				return;
			end
			exp_cmd = expected_commands.pop_front();
			checked++;
			if (code !== exp_cmd.code) begin
				$error("command_code: expected %0d, actual %0d", exp_cmd.code, code);
				errors++;
			end
			if (value !== exp_cmd.value) begin
				$error("cmd_value: expected %0d, actual %0d", exp_cmd.value, value);
				errors++;
			end
		endfunction
	endclass

	logic                   clk;
	logic                   arst_n;
	logic                   in_valid;
	logic                   in_ready;
	logic                   action;
	logic [7:0]             char_code;
	logic                   out_valid;
	logic                   out_ready;
	logic [CodeW-1:0]       command_code;
	logic signed [ValW-1:0] cmd_value;

	command_scoreboard sb = new();

	int items_sent   = 0;
	int lines_sent   = 0;
	int cycles       = 0;
	bit sender_burst = 1'b0;
	bit hold_req     = 1'b0;

	string      cmd_names[16] = '{"st", "rt", "tt", "ac", "ar", "sm", "po", "fa",
		"z1", "z2", "d1", "d2", "t1", "t2", "v1", "v2"};
	string      first_set     = "srazdtvfp";
	logic [7:0] blank_chars[4] = '{CH_SPACE, CH_TAB, CH_CR, CH_LF};

	console_command_line_parser uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.action       (action),
		.char_code    (char_code),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.command_code (command_code),
		.cmd_value    (cmd_value)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles >= LIMIT_CYCLES) begin
			$display("status: fail");
			$finish;
		end
	end

	// Offer one input transaction after a random gap and wait for acceptance
	task automatic send_item(input logic eol, input logic [7:0] ch);
		int gap;
		gap = sender_burst ? 0 : $urandom_range(0, 7);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid  <= 1'b1;
		action    <= eol;
		char_code <= ch;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sb.note_input(eol, ch);
		items_sent++;
		if (eol)
			lines_sent++;
	endtask

	// Characters of a string, then end of line unless told otherwise
	task automatic send_text(input string s, input bit eol = 1'b1);
		for (int i = 0; i < s.len(); i++)
			send_item(1'b0, s[i]);
		if (eol)
			send_item(1'b1, 8'($urandom));
	endtask

	// Mostly well-formed commands with random content, plus noise and broken lines
	task automatic random_line();
		logic [7:0] text[$];
		int         kind, n;
		string      pair;
		kind         = $urandom_range(0, 9);
		sender_burst = ($urandom_range(0, 4) == 0);
		if (kind <= 7) begin
			repeat ($urandom_range(0, 2)) text.push_back(blank_chars[$urandom_range(0, 3)]);
			if ($urandom_range(0, 4) == 0)
				text.push_back(8'($urandom_range("g", "o")));
			pair = cmd_names[$urandom_range(0, 15)];
			text.push_back(pair[0]);
			text.push_back(pair[1]);
			if ($urandom_range(0, 4) == 0)
				text.push_back(8'($urandom_range(33, 126)));
			// kind 7 leaves out the equals sign
			if (kind != 7)
				text.push_back(CH_EQUAL);
			if ($urandom_range(0, 2) == 0)
				text.push_back(CH_MINUS);
			n = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 12) : $urandom_range(0, 5);
			repeat (n) begin
				text.push_back(8'($urandom_range(CH_0, CH_9)));
				if ($urandom_range(0, 19) == 0)
					text.push_back(CH_MINUS);
			end
			if ($urandom_range(0, 4) == 0) begin
				text.push_back(blank_chars[$urandom_range(0, 3)]);
				repeat ($urandom_range(1, 4)) text.push_back(8'($urandom_range(33, 126)));
			end
		end else if (kind == 8) begin
			repeat ($urandom_range(0, 10)) text.push_back(8'($urandom_range(0, 255)));
		end else begin
			text.push_back(first_set[$urandom_range(0, 8)]);
			repeat ($urandom_range(1, 3)) text.push_back(8'($urandom_range(CH_1, "z")));
			text.push_back(CH_EQUAL);
			repeat ($urandom_range(0, 4)) text.push_back(8'($urandom_range(CH_0, CH_9)));
		end
		foreach (text[i])
			send_item(1'b0, text[i]);
		send_item(1'b1, 8'($urandom));
	endtask

	// Receiver: random stalls, bursts without stalls, one long hold-off
	initial begin
		int stall;
		int burst_left;
		burst_left = 0;
		out_ready <= 1'b0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			if (burst_left > 0) begin
				stall = 0;
				burst_left--;
			end else begin
				stall = $urandom_range(0, 7);
				if ($urandom_range(0, 9) == 0)
					burst_left = 12;
			end
			if (hold_req) begin
				hold_req = 1'b0;
				stall    = LONG_HOLD;
			end
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
			sb.check_command(command_code, cmd_value);
		end
	end

	// Stimulus and end of run
	initial begin
		int base;
		arst_n    <= 1'b0;
		in_valid  <= 1'b0;
		action    <= 1'b0;
		char_code <= CH_NUL;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty line, every command, extremes and corner cases
		send_item(1'b1, 8'hFF);
		send_text("st=0");
		foreach (blank_chars[i])
			send_item(1'b0, blank_chars[i]);
		send_text("rt=2147483647");
		send_text("tt=-1");
		send_text("ac=99999999999");
		send_text("ar=-99999999999");
		send_text("sm=12-34");
		send_text("po=5");
		send_text("fa=6");
		send_text("z1=1");
		send_text("z2=2");
		send_text("d1=3");
		send_text("d2=4");
		send_text("t1=5");
		send_text("t2=6");
		send_text("v1=7");
		send_text("v2=8");
		send_text("xqst=9");
		send_text("s1t=3");
		send_text("stx=4a5");
		send_text("st 5");
		send_text("st=7 =9");
		// NUL before the token kills the line, NUL inside ends the token
		send_item(1'b0, CH_NUL);
		send_text("st=3");
		send_text("po=1", 1'b0);
		send_item(1'b0, CH_NUL);
		send_text("2");
		send_item(1'b0, 8'hFF);
		send_item(1'b0, 8'h80);
		send_text("fa=1");

		// Random lines; the receiver holds off early so the block backs up
		hold_req = 1'b1;
		base = items_sent;
		while (items_sent - base < RANDOM_ITEMS)
			random_line();
		in_valid <= 1'b0;

		while (sb.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);

		$display("run covered %0d lines in %0d input transactions, %0d results checked",
			lines_sent, items_sent, sb.checked);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
